/* sv/pidx_pkg.sv */
// pidx_pkg: shared types, constants and helper functions for the packed index unpacker
// no dependencies

package pidx_pkg;

  localparam int unsigned WordBits     = 32;
  localparam int unsigned MaxWidth     = 16;
  localparam int unsigned CountBits    = 12;
  localparam int unsigned ValueBits    = 17;
  localparam int unsigned WidthBits    = 5;
  localparam int unsigned FieldCntBits = 6;

  localparam logic [CountBits-1:0] LayerLast = 12'hfff;
  localparam logic [WidthBits-1:0] WidthReset = 5'd4;

  // one result transaction
  typedef struct packed {
    logic [ValueBits-1:0] palette_value;
    logic [CountBits-1:0] position;
    logic                 last_in_word;
    logic                 last_in_layer;
  } pidx_result_t;

  // zero acts as width 1, anything above 16 saturates
  function automatic logic [WidthBits-1:0] eff_width(input logic [WidthBits-1:0] bpi);
    logic [WidthBits-1:0] w;
    begin
      w = bpi;
      if (bpi == '0) begin
        w = 5'd1;
      end else if (bpi > 5'd16) begin
        w = 5'd16;
      end
      return w;
    end
  endfunction

  // fields per 32-bit word, floor(32/w) for w in 1..16
  function automatic logic [FieldCntBits-1:0] fields_per_word(input logic [WidthBits-1:0] w);
    logic [FieldCntBits-1:0] n;
    begin
      unique case (w)
        5'd1:    n = 6'd32;
        5'd2:    n = 6'd16;
        5'd3:    n = 6'd10;
        5'd4:    n = 6'd8;
        5'd5:    n = 6'd6;
        5'd6:    n = 6'd5;
        5'd7:    n = 6'd4;
        5'd8:    n = 6'd4;
        5'd9:    n = 6'd3;
        5'd10:   n = 6'd3;
        5'd11:   n = 6'd2;
        5'd12:   n = 6'd2;
        5'd13:   n = 6'd2;
        5'd14:   n = 6'd2;
        5'd15:   n = 6'd2;
        5'd16:   n = 6'd2;
        default: n = 6'd32;
      endcase
      return n;
    end
  endfunction

  // x from u[11:8] in the low nibble, y from u[3:0] in the middle, z from u[7:4] on top
  function automatic logic [CountBits-1:0] permute_pos(input logic [CountBits-1:0] u);
    return {u[7:4], u[3:0], u[11:8]};
  endfunction

endpackage

/* sv/packed_index_unpacker.sv */
// packed_index_unpacker: top level, configuration register and the two stages
// depends on pidx_pkg, pidx_word_stage, pidx_out_reg

// Takes 32-bit storage words on the in_ channel and splits each into
// floor(32/width) palette indices, lowest bits first, where width is the
// cfg_bits_per_index register (reset 4; 0 acts as 1, above 16 acts as 16).
// Every index leaves on the out_ channel as one transaction: the index plus
// one, its permuted position x + 16*y + 256*z taken from a running 12-bit
// counter, and flags for the last index of the word and the 4096th index of
// the layer. The layer flag ends the word early: the remaining fields are
// dropped and the counter wraps for the next layer. The result channel moves
// one transaction per cycle while out_ready is high, so a word occupies the
// block for floor(32/width) results (32 at width 1, 2 at widths 11..16), fewer
// when a layer ends inside it; the single result path through the output
// register sets that rate. The next word is taken in the same cycle as the last
// field of the current one leaves the word stage, so a steady stream sees no
// gap between words. A word's fields pass the word register, then the result register.
// Write the register only while the block is idle; cfg_ready is always high.

module packed_index_unpacker (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pidx_pkg::WidthBits-1:0]      cfg_bits_per_index,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pidx_pkg::WordBits-1:0]       in_packed_word,
  // result indices
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pidx_pkg::ValueBits-1:0]      out_palette_value,
  output logic [pidx_pkg::CountBits-1:0]      out_position,
  output logic                                out_last_in_word,
  output logic                                out_last_in_layer
);

  logic [pidx_pkg::WidthBits-1:0] bpi_r;
  logic [pidx_pkg::WidthBits-1:0] width;

  logic                   res_valid;
  logic                   res_ready;
  pidx_pkg::pidx_result_t res;
  pidx_pkg::pidx_result_t out_res;

  // register write is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpi_r <= pidx_pkg::WidthReset;
    end else if (cfg_valid) begin
      bpi_r <= cfg_bits_per_index;
    end
  end

  // clamped field width used by both the field count and the extraction
  assign width = pidx_pkg::eff_width(bpi_r);

  // word register: holds the current word, shifts one field out per result
  pidx_word_stage u_word (
    .clk       (clk),
    .rst_n     (rst_n),
    .width     (width),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_packed_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // result register: registers the result transaction; out_ready reaches the word stage combinationally
  pidx_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_palette_value = out_res.palette_value;
  assign out_position      = out_res.position;
  assign out_last_in_word  = out_res.last_in_word;
  assign out_last_in_layer = out_res.last_in_layer;

endmodule

/* sv/pidx_word_stage.sv */
// pidx_word_stage: input word register, field counter and layer index counter
// depends on pidx_pkg

module pidx_word_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [pidx_pkg::WidthBits-1:0]      width,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pidx_pkg::WordBits-1:0]       in_word,
  output logic                                res_valid,
  input  logic                                res_ready,
  output pidx_pkg::pidx_result_t              res
);

  logic [pidx_pkg::WordBits-1:0]     word_r, word_nxt;
  logic [pidx_pkg::FieldCntBits-1:0] left_r, left_nxt;
  logic [pidx_pkg::CountBits-1:0]    cnt_r, cnt_nxt;

  logic                              hold_valid;
  logic                              fire;
  logic                              layer_end;
  logic                              last;
  logic                              accept;
  logic [pidx_pkg::MaxWidth-1:0]     mask;
  logic [pidx_pkg::MaxWidth-1:0]     field;

  assign hold_valid = (left_r != '0);
  assign fire       = hold_valid && res_ready;
  assign layer_end  = (cnt_r == pidx_pkg::LayerLast);
  assign last       = layer_end || (left_r == 6'd1);
  assign in_ready   = !hold_valid || (fire && last);
  assign accept     = in_valid && in_ready;

  assign mask  = 16'hffff >> (5'd16 - width);
  assign field = word_r[pidx_pkg::MaxWidth-1:0] & mask;

  assign res_valid         = hold_valid;
  assign res.palette_value = {1'b0, field} + 17'd1;
  assign res.position      = pidx_pkg::permute_pos(cnt_r);
  assign res.last_in_word  = last;
  assign res.last_in_layer = layer_end;

  always_comb begin
    word_nxt = word_r;
    left_nxt = left_r;
    cnt_nxt  = cnt_r;
    if (fire) begin
      word_nxt = word_r >> width;
      left_nxt = last ? '0 : left_r - 6'd1;
      cnt_nxt  = cnt_r + 12'd1;
    end
    if (accept) begin
      word_nxt = in_word;
      left_nxt = pidx_pkg::fields_per_word(width);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      cnt_r  <= '0;
    end else begin
      left_r <= left_nxt;
      cnt_r  <= cnt_nxt;
    end
    word_r <= word_nxt;
  end

endmodule

/* sv/pidx_out_reg.sv */
// pidx_out_reg: registered result stage between the word stage and the out_ channel
// depends on pidx_pkg

module pidx_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  output logic                   res_ready,
  input  pidx_pkg::pidx_result_t res,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pidx_pkg::pidx_result_t out_res
);

  logic                   valid_r;
  pidx_pkg::pidx_result_t data_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

endmodule

/* sv/pidx_checker.sv */
// pidx_checker: port-level assertions for packed_index_unpacker, bound to the top level
// depends on pidx_pkg

module pidx_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [pidx_pkg::ValueBits-1:0]      out_palette_value,
  input logic [pidx_pkg::CountBits-1:0]      out_position,
  input logic                                out_last_in_word,
  input logic                                out_last_in_layer
);

  // a stalled result transaction stays valid and holds its value, position and word flag
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_palette_value)
      && $stable(out_position) && $stable(out_last_in_word))
    else $error("stalled result changed");

  // reset empties the result register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // palette value is index plus one, never zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_palette_value != '0)
    else $error("palette value zero");

  // layer end also closes the word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_in_layer |-> out_last_in_word)
    else $error("layer end without word end");

  // the 4096th index maps to the last position
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_in_layer |-> out_position == pidx_pkg::LayerLast)
    else $error("layer end at wrong position");

endmodule

bind packed_index_unpacker pidx_checker u_pidx_checker (.*);

/* bench/tb_top.sv */
// tb_top: self-checking bench for packed_index_unpacker, predicts every index transaction
// from each accepted word and compares it field by field on the result channel
// depends on pidx_pkg and packed_index_unpacker

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WidthBits = pidx_pkg::WidthBits;
  localparam int unsigned WordBits  = pidx_pkg::WordBits;
  localparam int unsigned ValueBits = pidx_pkg::ValueBits;
  localparam int unsigned CountBits = pidx_pkg::CountBits;
  localparam int unsigned MaxWidth  = pidx_pkg::MaxWidth;

  // slowest correct run is roughly 210 words at 32 indices each, every index
  // waiting out the longest receiver stall, plus the long hold
  localparam int unsigned CycleLimit  = 1_000_000;
  // first index leaves through the word and result registers once the word is taken, keep a few spare
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned LayerSize   = 4096;
  // enough mismatch lines to debug, without flooding the log
  localparam int unsigned ReportCap   = 200;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [WidthBits-1:0]  cfg_bits_per_index;
  logic                  in_valid;
  logic                  in_ready;
  logic [WordBits-1:0]   in_packed_word;
  logic                  out_valid;
  logic                  out_ready;
  logic [ValueBits-1:0]  out_palette_value;
  logic [CountBits-1:0]  out_position;
  logic                  out_last_in_word;
  logic                  out_last_in_layer;

  // mirror of the width register and the running layer counter
  logic [WidthBits-1:0]  width_reg;
  logic [CountBits-1:0]  layer_index;
  // indices still due on the result channel, oldest first
  pidx_pkg::pidx_result_t pending_indices[$];

  // idling knobs: longest wait per transaction on each side, 0 means none
  int unsigned           in_gap_max;
  int unsigned           out_stall_max;
  // one-shot request for a long receiver hold, in cycles
  int unsigned           hold_cycles;

  int unsigned           mismatches      = 0;
  int unsigned           indices_checked = 0;
  int unsigned           layers_closed   = 0;
  int unsigned           words_sent      = 0;
  int unsigned           cfg_writes      = 0;
  longint unsigned       cycle_count     = 0;

  packed_index_unpacker DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_bits_per_index (cfg_bits_per_index),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_packed_word     (in_packed_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_palette_value  (out_palette_value),
    .out_position       (out_position),
    .out_last_in_word   (out_last_in_word),
    .out_last_in_layer  (out_last_in_layer)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  function automatic int unsigned draw_wait(input int unsigned max_wait);
    return (max_wait == 0) ? 0 : $urandom_range(0, max_wait);
  endfunction

  // register value to field width: zero acts as one, above 16 saturates
  function automatic int unsigned field_width(input logic [WidthBits-1:0] bpi);
    if (bpi == '0) return 1;
    if (bpi > MaxWidth) return MaxWidth;
    return 32'(bpi);
  endfunction

  // mostly plain random words, with corner patterns mixed in
  function automatic logic [WordBits-1:0] random_word();
    logic [WordBits-1:0] one_hot;
    one_hot = 32'd1 << $urandom_range(0, 31);
    unique case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return one_hot;
      3: return ~one_hot;
      default: return $urandom();
    endcase
  endfunction

  // expected index transactions for one accepted word, updates the counter mirror
  task automatic predict_indices(input logic [WordBits-1:0] word);
    int unsigned            wd;
    int unsigned            n_fields;
    logic [WordBits-1:0]    rest;
    logic [WordBits-1:0]    field;
    pidx_pkg::pidx_result_t r;
    wd       = field_width(width_reg);
    n_fields = WordBits / wd;
    rest     = word;
    for (int unsigned k = 0; k < n_fields; k++) begin
      field           = rest & ((32'd1 << wd) - 32'd1);
      r.palette_value = ValueBits'(field + 32'd1);
      // x from the top nibble, y from the low nibble, z from the middle one
      r.position      = CountBits'(int'(layer_index[11:8]) + 16 * int'(layer_index[3:0])
                                   + 256 * int'(layer_index[7:4]));
      r.last_in_layer = (layer_index == pidx_pkg::LayerLast);
      // a layer end also closes the word, the remaining fields are dropped
      r.last_in_word  = r.last_in_layer || (k + 1 == n_fields);
      pending_indices.push_back(r);
      layer_index = layer_index + 12'd1;
      rest        = rest >> wd;
      if (r.last_in_layer) break;
    end
  endtask

  // offer one word after a random gap, hold it until taken, then predict
  task automatic send_word(input logic [WordBits-1:0] word);
    int unsigned gap;
    gap = draw_wait(in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_packed_word = word;
    do @(posedge clk); while (!in_ready);
    predict_indices(word);
    words_sent++;
  endtask

  // stop offering and wait until every expected index has come back
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_indices.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_width(input logic [WidthBits-1:0] bpi);
    settle();
    @(negedge clk);
    cfg_valid          = 1'b1;
    cfg_bits_per_index = bpi;
    do @(posedge clk); while (!cfg_ready);
    width_reg = bpi;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= ReportCap)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // width left at its reset value of 4, no register write yet
  task automatic test_reset_width();
    send_word(32'h0000_0000);
    send_word(32'hffff_ffff);
    send_word(32'h7654_3210);
    send_word(32'hfedc_ba98);
    settle();
  endtask

  // narrowest and widest fields, plus the out of range register values
  task automatic test_width_extremes();
    write_width(5'd1);
    send_word(32'h0000_0000);
    send_word(32'hffff_ffff);
    send_word(32'h5555_5555);
    write_width(5'd16);
    send_word(32'hffff_ffff);
    send_word(32'h0000_ffff);
    send_word(32'hffff_0000);
    // zero acts as width 1
    write_width(5'd0);
    send_word(32'ha5a5_a5a5);
    // anything above 16 saturates to 16
    write_width(5'd31);
    send_word(32'h1234_5678);
    send_word(32'hffff_ffff);
    write_width(5'd17);
    send_word(32'hdead_beef);
  endtask

  // widths that leave unused high bits, which must never reach a field
  task automatic test_leftover_bits();
    write_width(5'd3);
    send_word(32'hffff_ffff);
    send_word(32'hc000_0000);
    write_width(5'd5);
    send_word(32'hffff_ffff);
    write_width(5'd7);
    send_word(32'hf000_0000);
    send_word(32'hffff_ffff);
    write_width(5'd11);
    send_word(32'hffff_ffff);
    settle();
  endtask

  // run the counter through a whole layer that ends inside a word, then into the next
  task automatic test_layer_wrap();
    int unsigned words_left;
    int unsigned first_part;
    in_gap_max    = 14;
    out_stall_max = 3;
    // make sure the layer end falls inside a width-1 word
    if (layer_index[4:0] == 5'd0) begin
      write_width(5'd3);
      send_word(random_word());
    end
    write_width(5'd1);
    words_left = (LayerSize - layer_index + 31) / 32;
    first_part = words_left / 2;
    repeat (first_part) send_word(random_word());
    // rest of the layer at full rate on both sides
    in_gap_max    = 0;
    out_stall_max = 0;
    repeat (words_left - first_part) send_word(random_word());
    // counter is back at zero, first word of the following layer
    send_word(random_word());
    settle();
    in_gap_max    = 14;
    out_stall_max = 14;
  endtask

  // receiver holds off long enough to fill the block and stall its input
  task automatic test_backpressure();
    write_width(5'd2);
    in_gap_max  = 0;
    hold_cycles = 300;
    repeat (24) send_word(random_word());
    // sender pauses here until every index is back
    settle();
    in_gap_max = 14;
  endtask

  // random register settings, each with its own idling pattern
  task automatic test_random_phases();
    for (int phase = 0; phase < 8; phase++) begin
      write_width(WidthBits'($urandom_range(0, 31)));
      unique case (phase % 4)
        0: begin in_gap_max = 14; out_stall_max = 14; end
        1: begin in_gap_max = 0;  out_stall_max = 0;  end
        2: begin in_gap_max = 14; out_stall_max = 0;  end
        default: begin in_gap_max = 0; out_stall_max = 14; end
      endcase
      repeat (5) send_word(random_word());
    end
    in_gap_max    = 14;
    out_stall_max = 14;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall before each transaction, or one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall       = (hold_cycles > 0) ? hold_cycles : draw_wait(out_stall_max);
      hold_cycles = 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every accepted index transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    pidx_pkg::pidx_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_indices.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportCap)
          $display("%0t: unexpected index transaction, value %0h position %0h",
                   $time, out_palette_value, out_position);
      end else begin
        want = pending_indices.pop_front();
        compare_field("palette_value", 32'(want.palette_value), 32'(out_palette_value));
        compare_field("position", 32'(want.position), 32'(out_position));
        compare_field("last_in_word", 32'(want.last_in_word), 32'(out_last_in_word));
        compare_field("last_in_layer", 32'(want.last_in_layer), 32'(out_last_in_layer));
        indices_checked++;
        if (want.last_in_layer) layers_closed++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run stopped after %0d cycles, %0d indices still due",
               $time, cycle_count, pending_indices.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    cfg_valid          = 1'b0;
    cfg_bits_per_index = '0;
    in_valid           = 1'b0;
    in_packed_word     = '0;
    width_reg          = pidx_pkg::WidthReset;
    layer_index        = '0;
    in_gap_max         = 14;
    out_stall_max      = 14;
    hold_cycles        = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_width();
    test_width_extremes();
    test_leftover_bits();
    test_layer_wrap();
    test_backpressure();
    test_random_phases();
    settle();

    $display("run covered %0d words over %0d width settings, %0d indices checked",
             words_sent, cfg_writes + 1, indices_checked);
    $display("including %0d layer ends, a long output hold and full-rate streams",
             layers_closed);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/pidx_pkg.sv
sv/pidx_word_stage.sv
sv/pidx_out_reg.sv
sv/packed_index_unpacker.sv
sv/pidx_checker.sv
bench/tb_top.sv
